[src/mtd_pkg.sv]
// maze turn decision package: mode and drive command types, register indexes
// and reset values shared by the decision logic
// no dependencies
package mtd_pkg;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_FIRST   = 2'd1,
        MODE_SECOND  = 2'd2,
        MODE_ROUND   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_STOP    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_LEFT    = 2'd2
    } t_cmd;

    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_word;

    // register indexes on the configuration port
    localparam t_cfg_idx CFG_COLLIDE = 3'd0;
    localparam t_cfg_idx CFG_QUARTER = 3'd1;
    localparam t_cfg_idx CFG_HALF    = 3'd2;
    localparam t_cfg_idx CFG_PERIOD  = 3'd3;
    localparam t_cfg_idx CFG_WRAP    = 3'd4;

    // register reset values
    localparam t_word RST_COLLIDE = 16'd300;
    localparam t_word RST_QUARTER = 16'd500;
    localparam t_word RST_HALF    = 16'd1000;
    localparam t_word RST_PERIOD  = 16'd65535;
    localparam t_word RST_WRAP    = 16'd32767;

    // margin between the two looks, in mm
    localparam t_word LOOK_MARGIN = 16'h00FF;

    // wrap-corrected difference of two encoder readings, 17 bits
    function automatic logic [16:0] wheel_delta(
        input t_word now_cnt,
        input t_word before_cnt,
        input t_word period,
        input t_word wrap_thr
    );
        t_word       hi;
        t_word       lo;
        t_word       diff;
        logic [16:0] up;
        logic [16:0] res;
        hi   = (now_cnt > before_cnt) ? now_cnt : before_cnt;
        lo   = (now_cnt > before_cnt) ? before_cnt : now_cnt;
        diff = hi - lo;
        up   = {1'b0, lo} + {1'b0, period};
        if (diff > wrap_thr) begin
            res = (up > {1'b0, hi}) ? (up - {1'b0, hi}) : 17'd0;
        end else begin
            res = {1'b0, diff};
        end
        return res;
    endfunction

endpackage

[src/maze_turn_decision_fsm.sv]
// maze turn decision machine: forward run with obstacle window, two looks
// and an optional turn round, all in one registered pass per item
// depends on mtd_pkg
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_ready | i_run_enable, i_distance_mm, i_left_count,
//          |                         | i_right_count
//  out     | o_out_valid/i_out_ready | o_drive_command, o_moving, o_mode
//  cfg     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// one item per cycle unless stalled; the result shows the cycle after accept.
// the state registers are the result register, so the whole decision (encoder
// deltas, saturating sum, target compare) is combinational logic before them.
// o_in_ready is low only while a result waits and i_out_ready is low.
// synchronous active-low reset restores registers, state and history.
module maze_turn_decision_fsm #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  mtd_pkg::t_cfg_idx    i_cfg_index,
    input  mtd_pkg::t_word       i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_run_enable,
    input  logic [15:0]          i_distance_mm,
    input  logic [15:0]          i_left_count,
    input  logic [15:0]          i_right_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_drive_command,
    output logic                 o_moving,
    output logic [1:0]           o_mode
);
    import mtd_pkg::*;

    localparam int HIST_SLOTS = (HISTORY_DEPTH > 1) ? HISTORY_DEPTH - 1 : 1;

    // configuration registers
    t_word r_collide, r_quarter, r_half, r_period, r_wrap;

    // decision state
    t_mode       r_mode, n_mode;
    t_cmd        r_cmd, n_cmd;
    logic        r_moving, n_moving;
    t_word       r_hist [HIST_SLOTS];
    t_word       r_last_left, n_last_left;
    t_word       r_last_right, n_last_right;
    logic [31:0] r_pulse_sum, n_pulse_sum;
    logic        r_turn_half, n_turn_half;
    t_word       r_first_dist, n_first_dist;
    logic        r_base_valid, n_base_valid;
    logic        r_out_valid;
    logic        n_hist_shift;

    logic        accept;
    logic        all_near;
    logic [17:0] add_pulses;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;
    logic [16:0] target;
    logic        turn_done;
    logic        far_first;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collide <= RST_COLLIDE;
            r_quarter <= RST_QUARTER;
            r_half    <= RST_HALF;
            r_period  <= RST_PERIOD;
            r_wrap    <= RST_WRAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLLIDE: r_collide <= i_cfg_data;
                CFG_QUARTER: r_quarter <= i_cfg_data;
                CFG_HALF:    r_half    <= i_cfg_data;
                CFG_PERIOD:  r_period  <= i_cfg_data;
                CFG_WRAP:    r_wrap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // obstacle window: current sample and all older ones below threshold
    always_comb begin
        all_near = i_distance_mm < r_collide;
        for (int i = 0; i < HIST_SLOTS; i++) begin
            if (!((HISTORY_DEPTH == 1) || (r_hist[i] < r_collide))) begin
                all_near = 1'b0;
            end
        end
    end

    // turn progress: encoder deltas, saturating sum, target compare
    always_comb begin
        add_pulses = {1'b0, wheel_delta(i_left_count, r_last_left, r_period, r_wrap)}
                   + {1'b0, wheel_delta(i_right_count, r_last_right, r_period, r_wrap)};
        sum_wide   = {1'b0, r_pulse_sum} + {15'd0, add_pulses};
        sum_sat    = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        target     = {(r_turn_half ? r_half : r_quarter), 1'b0};
        turn_done  = sum_sat >= {15'd0, target};
        far_first  = {1'b0, r_first_dist} > ({1'b0, i_distance_mm} + {1'b0, LOOK_MARGIN});
    end

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_cmd        = r_cmd;
        n_moving     = r_moving;
        n_last_left  = r_last_left;
        n_last_right = r_last_right;
        n_pulse_sum  = r_pulse_sum;
        n_turn_half  = r_turn_half;
        n_first_dist = r_first_dist;
        n_base_valid = r_base_valid;
        n_hist_shift = 1'b0;
        if (i_run_enable) begin
            if (r_moving) begin
                if (r_mode == MODE_FORWARD) begin
                    // forward run, watch the window
                    n_hist_shift = 1'b1;
                    if (all_near) begin
                        n_cmd    = CMD_STOP;
                        n_moving = 1'b0;
                    end else begin
                        n_cmd    = CMD_FORWARD;
                        n_moving = 1'b1;
                    end
                end else if (!r_base_valid) begin
                    // first tick of a turn only captures the baseline
                    n_last_left  = i_left_count;
                    n_last_right = i_right_count;
                    n_base_valid = 1'b1;
                end else begin
                    n_last_left  = i_left_count;
                    n_last_right = i_right_count;
                    n_pulse_sum  = sum_sat;
                    if (turn_done) begin
                        n_cmd    = CMD_STOP;
                        n_moving = 1'b0;
                    end
                end
            end else begin
                // manoeuvre finished: start the next one
                n_last_left  = '0;
                n_last_right = '0;
                n_pulse_sum  = '0;
                n_base_valid = 1'b0;
                n_moving     = 1'b1;
                unique case (r_mode)
                    MODE_FORWARD: begin
                        n_cmd       = CMD_LEFT;
                        n_mode      = MODE_FIRST;
                        n_turn_half = 1'b0;
                    end
                    MODE_FIRST: begin
                        n_cmd        = CMD_LEFT;
                        n_mode       = MODE_SECOND;
                        n_turn_half  = 1'b1;
                        n_first_dist = i_distance_mm;
                    end
                    MODE_SECOND: begin
                        if (far_first) begin
                            n_cmd       = CMD_LEFT;
                            n_mode      = MODE_ROUND;
                            n_turn_half = 1'b1;
                        end else begin
                            n_cmd  = CMD_FORWARD;
                            n_mode = MODE_FORWARD;
                        end
                    end
                    default: begin
                        n_cmd  = CMD_FORWARD;
                        n_mode = MODE_FORWARD;
                    end
                endcase
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_FORWARD;
            r_cmd        <= CMD_STOP;
            r_moving     <= 1'b1;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_pulse_sum  <= '0;
            r_turn_half  <= 1'b0;
            r_first_dist <= '0;
            r_base_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < HIST_SLOTS; i++) begin
                r_hist[i] <= RST_COLLIDE;
            end
        end else begin
            if (accept) begin
                r_mode       <= n_mode;
                r_cmd        <= n_cmd;
                r_moving     <= n_moving;
                r_last_left  <= n_last_left;
                r_last_right <= n_last_right;
                r_pulse_sum  <= n_pulse_sum;
                r_turn_half  <= n_turn_half;
                r_first_dist <= n_first_dist;
                r_base_valid <= n_base_valid;
                if (n_hist_shift) begin
                    for (int i = 0; i < HIST_SLOTS - 1; i++) begin
                        r_hist[i] <= r_hist[i + 1];
                    end
                    r_hist[HIST_SLOTS - 1] <= i_distance_mm;
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // outputs show the state after the last accepted item
    assign o_out_valid     = r_out_valid;
    assign o_drive_command = r_cmd;
    assign o_moving        = r_moving;
    assign o_mode          = r_mode;

    // a halted manoeuvre always drives stop
    a_stop_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> (r_cmd == CMD_STOP))
        else $error("halted but command is not stop");

    // any turning mode in progress drives left
    a_left_while_turning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_moving && (r_mode != MODE_FORWARD)) |-> (r_cmd == CMD_LEFT))
        else $error("turn in progress without left command");

    // an item with run low leaves the state untouched
    a_hold_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_run_enable) |=>
            ($stable(r_mode) && $stable(r_pulse_sum) && $stable(r_moving)))
        else $error("state changed on a disabled item");

    // every accepted item yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item left no result");

endmodule
